// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define RRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define RRE_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rre_pkg.sv =====
`default_nettype none

package rre_pkg;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_CLIP   = 3'd2,
        ACT_TRANS  = 3'd3,
        ACT_POINT  = 3'd4,
        ACT_BOUNDS = 3'd5,
        ACT_READ   = 3'd6,
        ACT_CLEAR  = 3'd7
    } t_action;

    // Stored entry: corners reach past 16 bits after cuts, sizes stay below 2^15.
    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_rect;

    // Edge arithmetic: left/top down to -32768, right/bottom up to ~98k, spans ~131k.
    typedef logic signed [18:0] t_edge;

    typedef struct packed {
        t_action            action;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic               is_empty;
    } t_cmd;

    typedef struct packed {
        logic               flag;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic               ovf;
        logic               last;
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_PIECE,
        ST_ADD_DEC,
        ST_LD_RD,
        ST_LD_EX,
        ST_ADD_CHK,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        OP_BND,
        OP_TRANS,
        OP_POINT,
        OP_CLIP,
        OP_READ,
        OP_CUT,
        OP_COPY
    } t_op;

    function automatic t_edge edge_of(input logic signed [16:0] p, input logic [14:0] s);
        return t_edge'(p) + t_edge'($signed({4'b0000, s}));
    endfunction

    // Command rectangle as a stored entry; only valid for a non-empty command.
    function automatic t_rect cmd_rect(input t_cmd c);
        t_rect r;
        r.x = {c.x[15], c.x};
        r.y = {c.y[15], c.y};
        r.w = c.w[14:0];
        r.h = c.h[14:0];
        return r;
    endfunction

    function automatic logic [15:0] sat16(input t_edge v);
        return (v > 19'sd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rre_fifo.sv =====
`default_nettype none

// Two-entry queue.
module rre_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  T     i_wdata,
    output logic o_full,
    input  logic i_rd,
    output T     o_rdata,
    output logic o_empty
);

    T           r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_ok;
    logic       rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) begin
                r_wp <= ~r_wp;
            end
            if (rd_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr_ok} - {1'b0, rd_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rre_front.sv =====
`default_nettype none

// Takes requests, decodes the action and flags empty rectangles, then queues them.
module rre_front
    import rre_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [2:0]         i_action,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_size_w,
    input  logic signed [15:0] i_size_h,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd cmd;
    logic q_empty;

    always_comb begin
        cmd.action   = t_action'(i_action);
        cmd.x        = i_pos_x;
        cmd.y        = i_pos_y;
        cmd.w        = i_size_w;
        cmd.h        = i_size_h;
        cmd.is_empty = (i_size_w <= 16'sd0) || (i_size_h <= 16'sd0);
    end

    rre_fifo #(.T(t_cmd)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_wdata (cmd),
        .o_full  (o_full),
        .i_rd    (i_cmd_pop),
        .o_rdata (o_cmd),
        .o_empty (q_empty)
    );

    assign o_cmd_valid = !q_empty;

endmodule

`default_nettype wire

// ===== hw/rtl/rre_back.sv =====
`default_nettype none

// Sequencer over the rectangle memory. Four buffers of 2**$clog2(MAX_RECTS) entries:
// the region list lives in one, two others hold work lists during add
// and one other holds the new list during subtract.
module rre_back
    import rre_pkg::*;
#(
    parameter int MAX_RECTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  t_cmd                           i_cmd,
    output logic                           o_cmd_pop,
    input  logic                           i_res_full,
    output logic                           o_res_wr,
    output t_res                           o_res,
    output logic [$clog2(MAX_RECTS+1)-1:0] o_res_cnt
);

    localparam int CW    = $clog2(MAX_RECTS + 1);
    localparam int IW    = $clog2(MAX_RECTS);
    localparam int AW    = IW + 2;
    localparam int DEPTH = 1 << AW;

    t_rect          r_mem [DEPTH];
    t_rect          r_rd;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    t_rect          mem_wd;
    logic           mem_re;
    logic [AW-1:0]  mem_ra;

    t_state         r_state, n_state;
    t_op            r_op, n_op;
    t_cmd           r_cmd, n_cmd;
    logic [1:0]     r_rb, n_rb;
    logic [1:0]     r_src, n_src;
    logic [1:0]     r_dst, n_dst;
    logic [1:0]     r_wb, n_wb;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_dn, n_dn;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_wn, n_wn;
    logic           r_flag, n_flag;
    logic           r_ovf, n_ovf;
    t_rect          r_clip, n_clip;
    t_edge          r_cr, n_cr;
    t_edge          r_cb, n_cb;
    t_edge          r_bx, n_bx;
    t_edge          r_by, n_by;
    t_edge          r_br, n_br;
    t_edge          r_bb, n_bb;
    t_rect          r_pc [4];
    t_rect          n_pc [4];
    logic [3:0]     r_pm, n_pm;

    // entry under work against the clip rectangle
    t_edge sx, sy, sr, sb, cx, cy, ox, oy, orr, ob, ow, oh;
    logic  meet_empty;
    logic  pt_inside;
    logic  last_i;
    logic signed [16:0] tx_sum, ty_sum;
    logic [CW-1:0] cpy_idx;
    logic [CW:0]   add_total;
    logic  hold_br, hold_rb;
    t_edge bw, bh;
    t_rect cr;
    logic [1:0] pk;

    assign sx  = t_edge'(r_rd.x);
    assign sy  = t_edge'(r_rd.y);
    assign sr  = edge_of(r_rd.x, r_rd.w);
    assign sb  = edge_of(r_rd.y, r_rd.h);
    assign cx  = t_edge'(r_clip.x);
    assign cy  = t_edge'(r_clip.y);
    assign ox  = (sx > cx) ? sx : cx;
    assign oy  = (sy > cy) ? sy : cy;
    assign orr = (sr < r_cr) ? sr : r_cr;
    assign ob  = (sb < r_cb) ? sb : r_cb;
    assign ow  = orr - ox;
    assign oh  = ob - oy;
    assign meet_empty = (ow <= 19'sd0) || (oh <= 19'sd0);
    // clip register holds the command point during a point test
    assign pt_inside = (cx >= sx) && (cx < sr) && (cy >= sy) && (cy < sb);
    assign last_i    = ((r_i + CW'(1)) == r_n);
    assign tx_sum    = r_rd.x + {r_cmd.x[15], r_cmd.x};
    assign ty_sum    = r_rd.y + {r_cmd.y[15], r_cmd.y};
    assign cpy_idx   = r_cnt + r_i;
    assign add_total = {1'b0, r_cnt} + {1'b0, r_wn};
    assign hold_br   = (r_bx <= cx) && (r_by <= cy) && (r_cr <= r_br) && (r_cb <= r_bb);
    assign hold_rb   = (cx <= r_bx) && (cy <= r_by) && (r_br <= r_cr) && (r_bb <= r_cb);
    assign bw        = r_br - r_bx;
    assign bh        = r_bb - r_by;
    assign cr        = cmd_rect(i_cmd);
    assign pk        = r_pm[0] ? 2'd0 : (r_pm[1] ? 2'd1 : (r_pm[2] ? 2'd2 : 2'd3));
    assign o_res_cnt = r_cnt;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cmd   = r_cmd;
        n_rb    = r_rb;
        n_src   = r_src;
        n_dst   = r_dst;
        n_wb    = r_wb;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_i     = r_i;
        n_dn    = r_dn;
        n_j     = r_j;
        n_wn    = r_wn;
        n_flag  = r_flag;
        n_ovf   = r_ovf;
        n_clip  = r_clip;
        n_cr    = r_cr;
        n_cb    = r_cb;
        n_bx    = r_bx;
        n_by    = r_by;
        n_br    = r_br;
        n_bb    = r_bb;
        n_pc    = r_pc;
        n_pm    = r_pm;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = r_rd;
        mem_re  = 1'b0;
        mem_ra  = {r_src, r_i[IW-1:0]};
        o_cmd_pop = 1'b0;
        o_res_wr  = 1'b0;
        o_res     = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd  = i_cmd;
                    n_flag = 1'b0;
                    n_ovf  = 1'b0;
                    n_clip = cr;
                    n_cr   = edge_of(cr.x, cr.w);
                    n_cb   = edge_of(cr.y, cr.h);
                    n_i    = '0;
                    n_dn   = '0;
                    n_src  = r_rb;
                    n_n    = r_cnt;
                    n_dst  = r_rb + 2'd1;
                    n_state = ST_RESP;
                    case (i_cmd.action)
                        ACT_ADD: begin
                            if (i_cmd.is_empty) begin
                                n_state = ST_RESP;
                            end else if (r_cnt == '0) begin
                                mem_we = 1'b1;
                                mem_wa = {r_rb, {IW{1'b0}}};
                                mem_wd = cr;
                                n_cnt  = CW'(1);
                                n_flag = 1'b1;
                            end else begin
                                n_op    = OP_BND;
                                n_state = ST_RD;
                            end
                        end
                        ACT_SUB: begin
                            if (!i_cmd.is_empty && r_cnt != '0) begin
                                n_op    = OP_CUT;
                                n_state = ST_RD;
                            end
                        end
                        ACT_CLIP: begin
                            if (i_cmd.is_empty) begin
                                n_cnt = '0;
                            end else if (r_cnt != '0) begin
                                n_op    = OP_CLIP;
                                n_state = ST_RD;
                            end
                        end
                        ACT_TRANS: begin
                            if (r_cnt != '0) begin
                                n_op    = OP_TRANS;
                                n_state = ST_RD;
                            end
                        end
                        ACT_POINT: begin
                            if (r_cnt != '0) begin
                                n_op    = OP_POINT;
                                n_state = ST_RD;
                            end
                        end
                        ACT_BOUNDS: begin
                            if (r_cnt != '0) begin
                                n_op    = OP_BND;
                                n_state = ST_RD;
                            end
                        end
                        ACT_READ: begin
                            if (r_cnt != '0) begin
                                n_op    = OP_READ;
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                            n_cnt = '0;
                        end
                    endcase
                end
            end

            ST_RD: begin
                mem_re  = 1'b1;
                mem_ra  = {r_src, r_i[IW-1:0]};
                n_state = ST_EX;
            end

            ST_EX: begin
                n_i     = r_i + CW'(1);
                n_state = last_i ? ST_RESP : ST_RD;
                case (r_op)
                    OP_BND: begin
                        n_bx = (r_i == '0 || sx < r_bx) ? sx : r_bx;
                        n_by = (r_i == '0 || sy < r_by) ? sy : r_by;
                        n_br = (r_i == '0 || sr > r_br) ? sr : r_br;
                        n_bb = (r_i == '0 || sb > r_bb) ? sb : r_bb;
                        if (last_i && r_cmd.action == ACT_ADD) begin
                            n_state = ST_ADD_DEC;
                        end
                    end
                    OP_TRANS: begin
                        mem_we   = 1'b1;
                        mem_wa   = {r_rb, r_i[IW-1:0]};
                        mem_wd.x = {tx_sum[15], tx_sum[15:0]};
                        mem_wd.y = {ty_sum[15], ty_sum[15:0]};
                    end
                    OP_POINT: begin
                        if (pt_inside) begin
                            n_flag  = 1'b1;
                            n_state = ST_RESP;
                        end
                    end
                    OP_CLIP: begin
                        if (!meet_empty) begin
                            mem_we   = 1'b1;
                            mem_wa   = {r_rb, r_dn[IW-1:0]};
                            mem_wd.x = ox[16:0];
                            mem_wd.y = oy[16:0];
                            mem_wd.w = ow[14:0];
                            mem_wd.h = oh[14:0];
                        end
                        n_dn = r_dn + CW'(!meet_empty);
                        if (last_i) begin
                            n_cnt = r_dn + CW'(!meet_empty);
                        end
                    end
                    OP_READ: begin
                        if (i_res_full) begin
                            n_i     = r_i;
                            n_state = ST_EX;
                        end else begin
                            o_res_wr   = 1'b1;
                            o_res.x    = r_rd.x[15:0];
                            o_res.y    = r_rd.y[15:0];
                            o_res.w    = {1'b0, r_rd.w};
                            o_res.h    = {1'b0, r_rd.h};
                            o_res.last = last_i;
                            n_state    = last_i ? ST_IDLE : ST_RD;
                        end
                    end
                    OP_CUT: begin
                        n_i     = r_i;
                        n_state = ST_PIECE;
                        if (meet_empty) begin
                            n_pm    = 4'b0001;
                            n_pc[0] = r_rd;
                        end else begin
                            n_pm = {orr < sr, ox > sx, ob < sb, oy > sy};
                            // top strip
                            n_pc[0]   = r_rd;
                            n_pc[0].h = 15'(oy - sy);
                            // bottom strip
                            n_pc[1]   = r_rd;
                            n_pc[1].y = ob[16:0];
                            n_pc[1].h = 15'(sb - ob);
                            // left strip
                            n_pc[2].x = r_rd.x;
                            n_pc[2].y = oy[16:0];
                            n_pc[2].w = 15'(ox - sx);
                            n_pc[2].h = oh[14:0];
                            // right strip
                            n_pc[3].x = orr[16:0];
                            n_pc[3].y = oy[16:0];
                            n_pc[3].w = 15'(sr - orr);
                            n_pc[3].h = oh[14:0];
                        end
                    end
                    OP_COPY: begin
                        mem_we = 1'b1;
                        mem_wa = {r_rb, cpy_idx[IW-1:0]};
                        mem_wd = r_rd;
                        if (last_i) begin
                            n_cnt  = r_cnt + r_n;
                            n_flag = 1'b1;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            ST_PIECE: begin
                if (r_pm != 4'b0000) begin
                    if (r_dn == CW'(MAX_RECTS)) begin
                        n_ovf   = 1'b1;
                        n_state = ST_RESP;
                    end else begin
                        mem_we   = 1'b1;
                        mem_wa   = {r_dst, r_dn[IW-1:0]};
                        mem_wd   = r_pc[pk];
                        n_dn     = r_dn + CW'(1);
                        n_pm[pk] = 1'b0;
                    end
                end else if (!last_i) begin
                    n_i     = r_i + CW'(1);
                    n_state = ST_RD;
                end else if (r_cmd.action == ACT_SUB) begin
                    n_rb    = r_dst;
                    n_cnt   = r_dn;
                    n_state = ST_RESP;
                end else if (r_dn == '0) begin
                    // new rectangle fully covered
                    n_state = ST_RESP;
                end else begin
                    n_wb = r_dst;
                    n_wn = r_dn;
                    if ((r_j + CW'(1)) == r_cnt) begin
                        n_state = ST_ADD_CHK;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = ST_LD_RD;
                    end
                end
            end

            ST_ADD_DEC: begin
                n_state = ST_RESP;
                if (r_cnt == CW'(1) && hold_br) begin
                    n_flag = 1'b0;
                end else if (hold_rb) begin
                    mem_we = 1'b1;
                    mem_wa = {r_rb, {IW{1'b0}}};
                    mem_wd = r_clip;
                    n_cnt  = CW'(1);
                    n_flag = 1'b1;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = {r_rb + 2'd1, {IW{1'b0}}};
                    mem_wd  = r_clip;
                    n_wb    = r_rb + 2'd1;
                    n_wn    = CW'(1);
                    n_j     = '0;
                    n_state = ST_LD_RD;
                end
            end

            ST_LD_RD: begin
                mem_re  = 1'b1;
                mem_ra  = {r_rb, r_j[IW-1:0]};
                n_state = ST_LD_EX;
            end

            ST_LD_EX: begin
                n_clip  = r_rd;
                n_cr    = sr;
                n_cb    = sb;
                n_src   = r_wb;
                n_n     = r_wn;
                n_dst   = (r_wb == r_rb + 2'd1) ? r_rb + 2'd2 : r_rb + 2'd1;
                n_i     = '0;
                n_dn    = '0;
                n_op    = OP_CUT;
                n_state = ST_RD;
            end

            ST_ADD_CHK: begin
                if (add_total > (CW+1)'(MAX_RECTS)) begin
                    n_ovf   = 1'b1;
                    n_state = ST_RESP;
                end else begin
                    n_src   = r_wb;
                    n_n     = r_wn;
                    n_i     = '0;
                    n_op    = OP_COPY;
                    n_state = ST_RD;
                end
            end

            ST_RESP: begin
                if (!i_res_full) begin
                    o_res_wr   = 1'b1;
                    o_res.flag = r_flag;
                    o_res.ovf  = r_ovf;
                    o_res.last = 1'b1;
                    if (r_cmd.action == ACT_BOUNDS && r_cnt != '0) begin
                        o_res.x = r_bx[15:0];
                        o_res.y = r_by[15:0];
                        o_res.w = sat16(bw);
                        o_res.h = sat16(bh);
                    end
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rb    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rb    <= n_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_cmd  <= n_cmd;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_wb   <= n_wb;
        r_n    <= n_n;
        r_i    <= n_i;
        r_dn   <= n_dn;
        r_j    <= n_j;
        r_wn   <= n_wn;
        r_flag <= n_flag;
        r_ovf  <= n_ovf;
        r_clip <= n_clip;
        r_cr   <= n_cr;
        r_cb   <= n_cb;
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_br   <= n_br;
        r_bb   <= n_bb;
        r_pc   <= n_pc;
        r_pm   <= n_pm;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rectangle_region_engine_top.sv =====
// Clear, or any action on an empty region, goes from idle straight to the response.
// Scans (bounds, clip, translate, point test) read and then execute each stored entry; read out
// gives one result per entry read and waits while the result queue is full. Subtract adds a
// piece step per entry that writes each piece. Add: a bounds scan, then per stored entry a load
// and a cut pass over the work list, then a copy of the appended entries into the region list.
// One action at a time; further requests wait in the request queue. Sync active-low reset.
`default_nettype none
`include "assert_macros.svh"

module rectangle_region_engine_top
    import rre_pkg::*;
#(
    parameter int MAX_RECTS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           push,
    output logic                           full,
    input  logic [2:0]                     i_action,
    input  logic signed [15:0]             i_pos_x,
    input  logic signed [15:0]             i_pos_y,
    input  logic signed [15:0]             i_size_w,
    input  logic signed [15:0]             i_size_h,
    // result side
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_flag,
    output logic signed [15:0]             o_out_x,
    output logic signed [15:0]             o_out_y,
    output logic [15:0]                    o_out_w,
    output logic [15:0]                    o_out_h,
    output logic [$clog2(MAX_RECTS+1)-1:0] o_entry_count,
    output logic                           o_overflow,
    output logic                           o_last
);

    localparam int CW = $clog2(MAX_RECTS + 1);

    // result plus the entry count after the action
    typedef struct packed {
        t_res          res;
        logic [CW-1:0] cnt;
    } t_out;

    logic          cmd_valid;
    t_cmd          cmd;
    logic          cmd_pop;
    logic          res_full;
    logic          res_wr;
    t_res          res;
    logic [CW-1:0] res_cnt;
    t_out          res_in;
    t_out          res_out;

    // Front end: decode and classify each request, queue it for the sequencer.
    rre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_size_w    (i_size_w),
        .i_size_h    (i_size_h),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: walks the rectangle memory and builds results.
    rre_back #(.MAX_RECTS(MAX_RECTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (res),
        .o_res_cnt   (res_cnt)
    );

    assign res_in.res = res;
    assign res_in.cnt = res_cnt;

    // Result queue decouples the sequencer from the consumer.
    rre_fifo #(.T(t_out)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_flag        = res_out.res.flag;
    assign o_out_x       = res_out.res.x;
    assign o_out_y       = res_out.res.y;
    assign o_out_w       = res_out.res.w;
    assign o_out_h       = res_out.res.h;
    assign o_overflow    = res_out.res.ovf;
    assign o_last        = res_out.res.last;
    assign o_entry_count = res_out.cnt;

    `RRE_ASSERT(a_cnt_cap, !empty |-> o_entry_count <= CW'(MAX_RECTS), "count above capacity")
    `RRE_ASSERT(a_ovf_last, !empty && o_overflow |-> o_last && !o_flag, "overflow not final")
    `RRE_ASSERT(a_flag_nobox, !empty && o_flag |-> o_out_w == 16'd0 && o_out_h == 16'd0, "flag with box")
    `RRE_ASSERT_ANY(a_rst_empty, $past(!i_rst_n) |-> empty, "result present after reset")

endmodule

`default_nettype wire
